>>> rtl/radio_mode_command_sequencer_macros.svh
// Assertion macros for the radio mode command sequencer.
`ifndef RADIO_MODE_COMMAND_SEQUENCER_MACROS_SVH
`define RADIO_MODE_COMMAND_SEQUENCER_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is asserted.
`define RMCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RMCS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/rmcs_pkg.sv
// Types and constants of the radio mode command sequencer.
package rmcs_pkg;

  localparam int unsigned FreqW  = 32;
  localparam int unsigned PowerW = 8;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [FreqW-1:0]  ThresholdReset = 32'd30000000;
  localparam logic [PowerW-1:0] PowerLowReset  = 8'd80;
  localparam logic [PowerW-1:0] PowerHighReset = 8'd100;
  localparam logic [ModeW-1:0]  CarrierModeReset = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_MOFF_RX  = 4'd1,
    ST_MOFF_TX  = 4'd2,
    ST_RX_FREQ  = 4'd3,
    ST_TX_FREQ  = 4'd4,
    ST_RX_OFF   = 4'd5,
    ST_TX_OFF   = 4'd6,
    ST_RX_MODE  = 4'd7,
    ST_TX_POWER = 4'd8,
    ST_TX_MODE  = 4'd9,
    ST_CARRIER  = 4'd10
  } seq_state_e;

  typedef enum logic [1:0] {
    OP_OFF     = 2'd0,
    OP_RX      = 2'd1,
    OP_TX      = 2'd2,
    OP_CARRIER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SET_OP     = 2'd0,
    KIND_SET_PARAMS = 2'd1,
    KIND_ACK        = 2'd2,
    KIND_RESET      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PARAM_FREQ  = 2'd0,
    PARAM_MODE  = 2'd1,
    PARAM_POWER = 2'd2
  } param_e;

  typedef enum logic {
    PATH_RX = 1'b0,
    PATH_TX = 1'b1
  } path_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_POWER_LOW = 2'd1,
    CFG_POWER_HIGH = 2'd2,
    CFG_CARRIER_MODE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             cmd_valid;
    path_e            cmd_path;
    param_e           cmd_param;
    logic [FreqW-1:0] cmd_value;
    logic             completed;
    seq_state_e       state_now;
  } result_t;

endpackage

>>> rtl/radio_mode_command_sequencer.sv
// Radio mode command sequencer: event-driven DSP command state machine.
//
//   channel  direction  handshake                   payload
//   in       in         in_valid_i / in_ready_o     kind, op_request, mod_code, frequency
//   out      out        out_valid_o / out_ready_i   cmd_*, completed, state_now
//   cfg      in         cfg_we_i (no wait)          cfg_idx_i, cfg_wdata_i
//
// One beat per cycle each way unless stalled; a result appears the cycle after its beat.
// The sequencer state is updated at the input beat, so the next beat sees it at once.
// The result register parts the two sides: a new beat is taken while the held result
// leaves in the same cycle; only a stalled, full result register holds off the input.
// Reset clears the sequencer state and loads the register defaults; no clearing pass.
`include "radio_mode_command_sequencer_macros.svh"

module radio_mode_command_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [rmcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rmcs_pkg::CfgW-1:0]       cfg_wdata_i,
  // event input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic [1:0]                      op_request_i,
  input  logic [rmcs_pkg::ModeW-1:0]      mod_code_i,
  input  logic [rmcs_pkg::FreqW-1:0]      frequency_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            cmd_valid_o,
  output logic                            cmd_path_o,
  output logic [1:0]                      cmd_param_o,
  output logic [rmcs_pkg::FreqW-1:0]      cmd_value_o,
  output logic                            completed_o,
  output logic [3:0]                      state_now_o
);
  import rmcs_pkg::*;

  // configuration registers
  logic [FreqW-1:0]  threshold_q;
  logic [PowerW-1:0] power_low_q;
  logic [PowerW-1:0] power_high_q;
  logic [ModeW-1:0]  carrier_mode_q;

  // sequencer state
  seq_state_e        seq_q, seq_d;
  op_e               op_q, op_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic [FreqW-1:0]  freq_q, freq_d;

  // step flags
  logic              issue;
  logic              done;
  logic              in_fire;

  // result register
  logic              out_valid_q;
  result_t           res_q, res_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= ThresholdReset;
      power_low_q    <= PowerLowReset;
      power_high_q   <= PowerHighReset;
      carrier_mode_q <= CarrierModeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:    threshold_q    <= cfg_wdata_i;
        CFG_POWER_LOW:    power_low_q    <= cfg_wdata_i[PowerW-1:0];
        CFG_POWER_HIGH:   power_high_q   <= cfg_wdata_i[PowerW-1:0];
        CFG_CARRIER_MODE: carrier_mode_q <= cfg_wdata_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Next state. 'issue' means the move asks for the new state's command.
  always_comb begin
    seq_d  = seq_q;
    op_d   = op_q;
    mode_d = mode_q;
    freq_d = freq_q;
    issue  = 1'b0;
    done   = 1'b0;
    if (in_fire) begin
      case (kind_e'(kind_i))
        KIND_SET_OP: begin
          if (op_e'(op_request_i) != op_q) begin
            op_d  = op_e'(op_request_i);
            issue = 1'b1;
            case (op_e'(op_request_i))
              OP_OFF: begin
                if (seq_q == ST_IDLE) begin
                  if (op_q == OP_RX) seq_d = ST_RX_OFF;
                  else if (op_q == OP_TX || op_q == OP_CARRIER) seq_d = ST_TX_OFF;
                  else issue = 1'b0;
                end else if (seq_q == ST_RX_MODE) begin
                  seq_d = ST_RX_OFF;
                end else if (seq_q == ST_TX_POWER) begin
                  // straight to idle, idle has no command
                  seq_d = ST_IDLE;
                end else if (seq_q inside {ST_TX_MODE, ST_CARRIER}) begin
                  seq_d = ST_TX_OFF;
                end else begin
                  issue = 1'b0;
                end
              end
              OP_RX: begin
                if (seq_q inside {ST_IDLE, ST_TX_MODE, ST_CARRIER})
                  seq_d = (op_q == OP_OFF) ? ST_RX_MODE : ST_TX_OFF;
                else if (seq_q inside {ST_RX_OFF, ST_TX_OFF, ST_TX_POWER})
                  seq_d = ST_RX_MODE;
                else
                  issue = 1'b0;
              end
              OP_TX: begin
                if (seq_q inside {ST_IDLE, ST_RX_MODE})
                  seq_d = (op_q == OP_OFF) ? ST_TX_POWER : ST_RX_OFF;
                else if (seq_q inside {ST_RX_OFF, ST_TX_OFF, ST_CARRIER})
                  seq_d = ST_TX_POWER;
                else
                  issue = 1'b0;
              end
              default: begin  // carrier
                if (seq_q inside {ST_IDLE, ST_RX_MODE})
                  seq_d = (op_q == OP_OFF) ? ST_TX_POWER : ST_RX_OFF;
                else if (seq_q inside {ST_RX_OFF, ST_TX_OFF, ST_TX_MODE})
                  seq_d = ST_TX_POWER;
                else
                  issue = 1'b0;
              end
            endcase
          end
        end
        KIND_SET_PARAMS: begin
          mode_d = mod_code_i;
          freq_d = frequency_i;
          issue  = 1'b1;
          if (seq_q == ST_IDLE) begin
            if (op_q == OP_OFF) seq_d = ST_RX_FREQ;
            else if (op_q == OP_RX) seq_d = ST_MOFF_RX;
            else seq_d = ST_MOFF_TX;
          end else if (seq_q inside {ST_RX_OFF, ST_TX_OFF, ST_RX_FREQ, ST_TX_FREQ}) begin
            seq_d = ST_RX_FREQ;
          end else if (seq_q inside {ST_TX_POWER, ST_TX_MODE, ST_CARRIER}) begin
            seq_d = ST_MOFF_TX;
          end else if (seq_q == ST_RX_MODE) begin
            seq_d = ST_MOFF_RX;
          end else begin
            // mode-off states: store only
            issue = 1'b0;
          end
        end
        KIND_ACK: begin
          if (seq_q != ST_IDLE) begin
            issue = 1'b1;
            case (seq_q)
              ST_MOFF_RX, ST_MOFF_TX: seq_d = ST_RX_FREQ;
              ST_RX_FREQ:             seq_d = ST_TX_FREQ;
              ST_TX_FREQ, ST_RX_OFF, ST_TX_OFF: begin
                if (op_q == OP_OFF) seq_d = ST_IDLE;
                else if (op_q == OP_RX) seq_d = ST_RX_MODE;
                else seq_d = ST_TX_POWER;
              end
              ST_TX_POWER: begin
                if (op_q == OP_TX) seq_d = ST_TX_MODE;
                else if (op_q == OP_CARRIER) seq_d = ST_CARRIER;
                else seq_d = ST_IDLE;
              end
              default: seq_d = ST_IDLE;
            endcase
            done = (seq_d == ST_IDLE);
          end
        end
        default: begin  // reset event, registers keep their values
          seq_d  = ST_IDLE;
          op_d   = OP_OFF;
          mode_d = '0;
          freq_d = '0;
        end
      endcase
    end
  end

  // Command of the new state, built from the post-step values.
  always_comb begin
    res_d           = '0;
    res_d.completed = done;
    res_d.state_now = seq_d;
    if (issue) begin
      res_d.cmd_valid = 1'b1;
      case (seq_d)
        ST_RX_FREQ: begin
          res_d.cmd_path  = PATH_RX;
          res_d.cmd_param = PARAM_FREQ;
          res_d.cmd_value = freq_d;
        end
        ST_TX_FREQ: begin
          res_d.cmd_path  = PATH_TX;
          res_d.cmd_param = PARAM_FREQ;
          res_d.cmd_value = freq_d;
        end
        ST_MOFF_RX, ST_RX_OFF: begin
          res_d.cmd_path  = PATH_RX;
          res_d.cmd_param = PARAM_MODE;
        end
        ST_MOFF_TX, ST_TX_OFF: begin
          res_d.cmd_path  = PATH_TX;
          res_d.cmd_param = PARAM_MODE;
        end
        ST_RX_MODE: begin
          res_d.cmd_path  = PATH_RX;
          res_d.cmd_param = PARAM_MODE;
          res_d.cmd_value = FreqW'(mode_d);
        end
        ST_TX_POWER: begin
          res_d.cmd_path  = PATH_TX;
          res_d.cmd_param = PARAM_POWER;
          // carrier always runs at the reduced level
          if (op_d != OP_CARRIER && freq_d < threshold_q)
            res_d.cmd_value = FreqW'(power_high_q);
          else
            res_d.cmd_value = FreqW'(power_low_q);
        end
        ST_TX_MODE: begin
          res_d.cmd_path  = PATH_TX;
          res_d.cmd_param = PARAM_MODE;
          res_d.cmd_value = FreqW'(mode_d);
        end
        ST_CARRIER: begin
          res_d.cmd_path  = PATH_TX;
          res_d.cmd_param = PARAM_MODE;
          res_d.cmd_value = FreqW'(carrier_mode_q);
        end
        default: res_d.cmd_valid = 1'b0;  // idle issues nothing
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= ST_IDLE;
      op_q        <= OP_OFF;
      mode_q      <= '0;
      freq_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q  <= seq_d;
      op_q   <= op_d;
      mode_q <= mode_d;
      freq_q <= freq_d;
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign cmd_valid_o = res_q.cmd_valid;
  assign cmd_path_o  = res_q.cmd_path;
  assign cmd_param_o = res_q.cmd_param;
  assign cmd_value_o = res_q.cmd_value;
  assign completed_o = res_q.completed;
  assign state_now_o = res_q.state_now;

  // A held result always reports the state the sequencer is in.
  `RMCS_ASSERT(a_state_tracks,
               out_valid_q |-> (res_q.state_now == seq_q),
               "result state differs from sequencer state")
  // Completion only lands in idle, which has no command.
  `RMCS_ASSERT(a_done_idle,
               (out_valid_q && res_q.completed) |->
                 (res_q.state_now == ST_IDLE && !res_q.cmd_valid),
               "completion outside idle")
  // No command means zero command fields.
  `RMCS_ASSERT(a_nocmd_zero,
               (out_valid_q && !res_q.cmd_valid) |->
                 (res_q.cmd_param == PARAM_FREQ && res_q.cmd_path == PATH_RX &&
                  res_q.cmd_value == '0),
               "stale command fields")
  // A reset event clears the sequencer.
  `RMCS_ASSERT(a_reset_event,
               (in_fire && kind_i == KIND_RESET) |=>
                 (seq_q == ST_IDLE && op_q == OP_OFF && freq_q == '0),
               "reset event left state")
  // Nothing is shown right out of reset.
  `RMCS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_q, "result valid in reset")

endmodule

>>> tb/rmcs_command_checker.sv
// Checker for the radio mode command sequencer: predicts each result and compares it.
module rmcs_command_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rmcs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rmcs_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   kind_i,
  input  logic [1:0]                   op_request_i,
  input  logic [rmcs_pkg::ModeW-1:0]   mod_code_i,
  input  logic [rmcs_pkg::FreqW-1:0]   frequency_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         cmd_valid_i,
  input  logic                         cmd_path_i,
  input  logic [1:0]                   cmd_param_i,
  input  logic [rmcs_pkg::FreqW-1:0]   cmd_value_i,
  input  logic                         completed_i,
  input  logic [3:0]                   state_now_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rmcs_pkg::*;

  // predictor state
  seq_state_e        cur_state;
  op_e               cur_op;
  logic [ModeW-1:0]  cur_mode;
  logic [FreqW-1:0]  cur_freq;
  // predictor copy of the registers
  logic [FreqW-1:0]  thresh_hz;
  logic [PowerW-1:0] pwr_lo;
  logic [PowerW-1:0] pwr_hi;
  logic [ModeW-1:0]  carrier_mode;

  result_t     expected_cmds[$];
  int unsigned errors;

  task automatic report_mismatch(string msg);
    if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Applies one event to the predicted sequencer and returns the result it causes.
  function automatic result_t advance_sequencer(kind_e k, op_e op, logic [ModeW-1:0] mode,
                                                logic [FreqW-1:0] freq);
    result_t    r;
    logic       issue;
    logic       done;
    seq_state_e s;
    r     = '0;
    issue = 1'b0;
    done  = 1'b0;
    s     = cur_state;
    case (k)
      KIND_SET_OP: begin
        if (op != cur_op) begin
          issue = 1'b1;
          case (op)
            OP_OFF: begin
              case (s)
                ST_IDLE: begin
                  if (cur_op == OP_RX) s = ST_RX_OFF;
                  else if (cur_op == OP_TX || cur_op == OP_CARRIER) s = ST_TX_OFF;
                  else issue = 1'b0;
                end
                ST_RX_MODE:             s = ST_RX_OFF;
                ST_TX_POWER:            s = ST_IDLE;
                ST_TX_MODE, ST_CARRIER: s = ST_TX_OFF;
                default:                issue = 1'b0;
              endcase
            end
            OP_RX: begin
              case (s)
                ST_IDLE, ST_TX_MODE, ST_CARRIER:
                  s = (cur_op == OP_OFF) ? ST_RX_MODE : ST_TX_OFF;
                ST_RX_OFF, ST_TX_OFF, ST_TX_POWER: s = ST_RX_MODE;
                default:                           issue = 1'b0;
              endcase
            end
            OP_TX: begin
              case (s)
                ST_IDLE, ST_RX_MODE:
                  s = (cur_op == OP_OFF) ? ST_TX_POWER : ST_RX_OFF;
                ST_RX_OFF, ST_TX_OFF, ST_CARRIER: s = ST_TX_POWER;
                default:                          issue = 1'b0;
              endcase
            end
            default: begin
              case (s)
                ST_IDLE, ST_RX_MODE:
                  s = (cur_op == OP_OFF) ? ST_TX_POWER : ST_RX_OFF;
                ST_RX_OFF, ST_TX_OFF, ST_TX_MODE: s = ST_TX_POWER;
                default:                          issue = 1'b0;
              endcase
            end
          endcase
          cur_op = op;
        end
      end
      KIND_SET_PARAMS: begin
        cur_mode = mode;
        cur_freq = freq;
        issue    = 1'b1;
        case (s)
          ST_IDLE: begin
            if (cur_op == OP_OFF) s = ST_RX_FREQ;
            else if (cur_op == OP_RX) s = ST_MOFF_RX;
            else s = ST_MOFF_TX;
          end
          ST_RX_OFF, ST_TX_OFF, ST_RX_FREQ, ST_TX_FREQ: s = ST_RX_FREQ;
          ST_TX_POWER, ST_TX_MODE, ST_CARRIER:         s = ST_MOFF_TX;
          ST_RX_MODE:                                  s = ST_MOFF_RX;
          default:                                     issue = 1'b0;
        endcase
      end
      KIND_ACK: begin
        if (s != ST_IDLE) begin
          case (s)
            ST_MOFF_RX, ST_MOFF_TX: s = ST_RX_FREQ;
            ST_RX_FREQ:             s = ST_TX_FREQ;
            ST_TX_FREQ, ST_RX_OFF, ST_TX_OFF: begin
              if (cur_op == OP_OFF) s = ST_IDLE;
              else if (cur_op == OP_RX) s = ST_RX_MODE;
              else s = ST_TX_POWER;
            end
            ST_TX_POWER: begin
              if (cur_op == OP_TX) s = ST_TX_MODE;
              else if (cur_op == OP_CARRIER) s = ST_CARRIER;
              else s = ST_IDLE;
            end
            default: s = ST_IDLE;
          endcase
          done  = (s == ST_IDLE);
          issue = 1'b1;
        end
      end
      default: begin
        s        = ST_IDLE;
        cur_op   = OP_OFF;
        cur_mode = '0;
        cur_freq = '0;
      end
    endcase
    cur_state = s;

    // command that belongs to the new state
    if (issue) begin
      case (s)
        ST_RX_FREQ: begin
          r.cmd_path = PATH_RX; r.cmd_param = PARAM_FREQ; r.cmd_value = cur_freq;
        end
        ST_TX_FREQ: begin
          r.cmd_path = PATH_TX; r.cmd_param = PARAM_FREQ; r.cmd_value = cur_freq;
        end
        ST_MOFF_RX, ST_RX_OFF: begin
          r.cmd_path = PATH_RX; r.cmd_param = PARAM_MODE; r.cmd_value = '0;
        end
        ST_MOFF_TX, ST_TX_OFF: begin
          r.cmd_path = PATH_TX; r.cmd_param = PARAM_MODE; r.cmd_value = '0;
        end
        ST_RX_MODE: begin
          r.cmd_path = PATH_RX; r.cmd_param = PARAM_MODE; r.cmd_value = 32'(cur_mode);
        end
        ST_TX_POWER: begin
          r.cmd_path  = PATH_TX;
          r.cmd_param = PARAM_POWER;
          if (cur_op != OP_CARRIER && cur_freq < thresh_hz) r.cmd_value = 32'(pwr_hi);
          else r.cmd_value = 32'(pwr_lo);
        end
        ST_TX_MODE: begin
          r.cmd_path = PATH_TX; r.cmd_param = PARAM_MODE; r.cmd_value = 32'(cur_mode);
        end
        ST_CARRIER: begin
          r.cmd_path = PATH_TX; r.cmd_param = PARAM_MODE; r.cmd_value = 32'(carrier_mode);
        end
        default: issue = 1'b0;
      endcase
    end
    r.cmd_valid = issue;
    r.completed = done;
    r.state_now = s;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t next_want;
    string   wrong;
    if (!rst_ni) begin
      cur_state    = ST_IDLE;
      cur_op       = OP_OFF;
      cur_mode     = '0;
      cur_freq     = '0;
      thresh_hz    = ThresholdReset;
      pwr_lo       = PowerLowReset;
      pwr_hi       = PowerHighReset;
      carrier_mode = CarrierModeReset;
      expected_cmds.delete();
      errors       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result beat: compare with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want  = expected_cmds.pop_front();
          wrong = "";
          if (cmd_valid_i !== want.cmd_valid)
            wrong = {wrong, $sformatf(" cmd_valid %0b/%0b", cmd_valid_i, want.cmd_valid)};
          if (cmd_path_i !== want.cmd_path)
            wrong = {wrong, $sformatf(" cmd_path %0b/%0b", cmd_path_i, want.cmd_path)};
          if (cmd_param_i !== want.cmd_param)
            wrong = {wrong, $sformatf(" cmd_param %0d/%0d", cmd_param_i, want.cmd_param)};
          if (cmd_value_i !== want.cmd_value)
            wrong = {wrong, $sformatf(" cmd_value %0h/%0h", cmd_value_i, want.cmd_value)};
          if (completed_i !== want.completed)
            wrong = {wrong, $sformatf(" completed %0b/%0b", completed_i, want.completed)};
          if (state_now_i !== want.state_now)
            wrong = {wrong, $sformatf(" state_now %0d/%0d", state_now_i, want.state_now)};
          if (wrong != "") report_mismatch({"got/want", wrong});
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD:  thresh_hz    = cfg_wdata_i;
          CFG_POWER_LOW:  pwr_lo       = cfg_wdata_i[PowerW-1:0];
          CFG_POWER_HIGH: pwr_hi       = cfg_wdata_i[PowerW-1:0];
          default:        carrier_mode = cfg_wdata_i[ModeW-1:0];
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        next_want = advance_sequencer(kind_e'(kind_i), op_e'(op_request_i),
                                      mod_code_i, frequency_i);
        expected_cmds.insert(expected_cmds.size(), next_want);
      end
      fail_count_o <= errors;
      pending_o    <= expected_cmds.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the sequencer testbench: clock, reset, event stimulus and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmcs_pkg::*;

  // Generous cycle budget: ~950 events, even with both sides stalling, plus the
  // register phases and drains.
  localparam int unsigned CycleLimit = 200000;
  // Events per register phase (split in two halves around a full drain).
  localparam int unsigned PhaseEvents = 132;
  localparam int unsigned NumPhases = 7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i = '0;
  logic [1:0]         op_request_i = '0;
  logic [ModeW-1:0]   mod_code_i = '0;
  logic [FreqW-1:0]   frequency_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               cmd_valid_o;
  logic               cmd_path_o;
  logic [1:0]         cmd_param_o;
  logic [FreqW-1:0]   cmd_value_o;
  logic               completed_o;
  logic [3:0]         state_now_o;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned events_sent = 0;
  int unsigned cycle_count = 0;
  logic [FreqW-1:0] thresh_now = ThresholdReset;  // steers frequencies around the threshold
  bit stalls_on = 1'b1;                            // random idling on both channels

  always #1 clk_i = ~clk_i;

  radio_mode_command_sequencer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .op_request_i (op_request_i),
    .mod_code_i   (mod_code_i),
    .frequency_i  (frequency_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_valid_o  (cmd_valid_o),
    .cmd_path_o   (cmd_path_o),
    .cmd_param_o  (cmd_param_o),
    .cmd_value_o  (cmd_value_o),
    .completed_o  (completed_o),
    .state_now_o  (state_now_o)
  );

  rmcs_command_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .kind_i       (kind_i),
    .op_request_i (op_request_i),
    .mod_code_i   (mod_code_i),
    .frequency_i  (frequency_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_valid_i  (cmd_valid_o),
    .cmd_path_i   (cmd_path_o),
    .cmd_param_i  (cmd_param_o),
    .cmd_value_i  (cmd_value_o),
    .completed_i  (completed_o),
    .state_now_i  (state_now_o),
    .fail_count_o (fail_count),
    .pending_o    (results_owed)
  );

  // Result side back-pressure: ready drops with a chance of 37 in 100 while stalls are on.
  always @(posedge clk_i) begin
    out_ready_i <= !stalls_on || ($urandom_range(99) >= 37);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one event beat and returns at the edge that accepts it. Valid is left
  // high: the next call either lowers it for a gap or replaces the payload in the
  // same step, so valid never drops and rises within one time step.
  task automatic send_event(kind_e k, op_e op, logic [ModeW-1:0] mode, logic [FreqW-1:0] freq);
    while (stalls_on && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    op_request_i <= op;
    mod_code_i   <= mode;
    frequency_i  <= freq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    events_sent++;
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  // Writes all four registers back to back; upper data bits of the narrow
  // registers carry junk that the block must drop.
  task automatic program_regs(logic [FreqW-1:0] thr, logic [PowerW-1:0] lo,
                              logic [PowerW-1:0] hi, logic [ModeW-1:0] cm);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_THRESHOLD;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_POWER_LOW;
    cfg_wdata_i <= {24'($urandom), lo};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_POWER_HIGH;
    cfg_wdata_i <= {24'($urandom), hi};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CARRIER_MODE;
    cfg_wdata_i <= {28'($urandom), cm};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thresh_now  = thr;
  endtask

  // One burst: an event, mostly a request, followed by a run of up to five acknowledges
  // that walks the sequencer along its command chain. Ignored payload fields stay random.
  task automatic random_burst();
    kind_e            k;
    logic [FreqW-1:0] f;
    int unsigned      sel;
    sel = $urandom_range(99);
    if (sel < 47) k = KIND_SET_OP;
    else if (sel < 94) k = KIND_SET_PARAMS;
    else if (sel < 97) k = KIND_ACK;
    else k = KIND_RESET;
    // frequencies cluster on the power threshold and the range ends
    case ($urandom_range(7))
      0:       f = '0;
      1:       f = '1;
      2:       f = thresh_now;
      3:       f = thresh_now - 1;
      4:       f = thresh_now + 1;
      default: f = $urandom;
    endcase
    send_event(k, op_e'(2'($urandom_range(3))), 4'($urandom_range(15)), f);
    repeat ($urandom_range(5))
      send_event(KIND_ACK, op_e'(2'($urandom_range(3))), 4'($urandom_range(15)), $urandom);
  endtask

  initial begin : stimulus
    int unsigned goal;
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk at the reset register values.
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // acknowledge at idle
    send_event(KIND_SET_OP, OP_OFF, 4'd0, 32'd0);            // same operation
    send_event(KIND_SET_PARAMS, OP_OFF, 4'd0, 32'd0);        // idle, off -> rx freq
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // back to idle, completed
    send_event(KIND_SET_OP, OP_RX, 4'd0, 32'd0);             // rx mode
    send_event(KIND_SET_OP, OP_RX, 4'd0, 32'd0);             // same operation
    send_event(KIND_SET_PARAMS, OP_OFF, 4'd15, 32'hFFFF_FFFF); // mode-off rx
    send_event(KIND_SET_PARAMS, OP_OFF, 4'd9, 32'd29_999_999); // stored only during mode-off
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // rx mode again
    send_event(KIND_SET_OP, OP_TX, 4'd0, 32'd0);             // rx off first
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // tx power, below threshold
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // tx mode
    send_event(KIND_SET_OP, OP_CARRIER, 4'd0, 32'd0);        // carrier power is always low
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // carrier mode code
    send_event(KIND_SET_OP, OP_OFF, 4'd0, 32'd0);            // tx off
    send_event(KIND_ACK, OP_OFF, 4'd0, 32'd0);               // idle, completed
    send_event(KIND_SET_OP, OP_TX, 4'd0, 32'd0);             // straight to tx power
    send_event(KIND_SET_OP, OP_OFF, 4'd0, 32'd0);            // off during tx power: silent idle
    send_event(KIND_SET_PARAMS, OP_OFF, 4'd3, 32'd30_000_000);
    send_event(KIND_SET_OP, OP_CARRIER, 4'd0, 32'd0);        // no move in rx freq, op still taken
    send_event(KIND_RESET, OP_RX, 4'd15, 32'hFFFF_FFFF);     // clears the sequencer only
    send_event(KIND_SET_OP, OP_TX, 4'd0, 32'd0);             // frequency cleared -> high power
    drain_results();

    // Random phases, each under its own register setting. The first three pin the
    // extremes and the defaults; the third runs with no idling at all.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       program_regs(32'd0, 8'd0, 8'd255, 4'd0);
        1:       program_regs(32'hFFFF_FFFF, 8'd255, 8'd0, 4'd15);
        2:       program_regs(ThresholdReset, PowerLowReset, PowerHighReset, CarrierModeReset);
        default: program_regs($urandom, 8'($urandom), 8'($urandom), 4'($urandom));
      endcase
      stalls_on = (phase != 2);
      repeat (2) begin
        goal = events_sent + PhaseEvents / 2;
        while (events_sent < goal) random_burst();
        // sender waits for every owed result before going on
        drain_results();
      end
    end
    stalls_on = 1'b1;

    drain_results();
    // Further idle cycles let any stray result beat show up.
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
